// ----- rtl/turntable_scratch_detector_unit_defines.svh -----
// Assertion macros for the turntable scratch detector RTL.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef TURNTABLE_SCRATCH_DETECTOR_UNIT_DEFINES_SVH
`define TURNTABLE_SCRATCH_DETECTOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tsd_pkg.sv -----
// Package for the turntable scratch detector: widths, event and key codes,
// register indexes and the result struct. No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

	// Position bits taken from the axis sample (8 to 16)
	localparam int PosBits = 16;
	localparam int PosInBits = 16;

	localparam int MinTicksBits = 4;
	localparam int StopBits = 5;
	localparam int CfgDataBits = 5;
	localparam int CfgIndexBits = 1;

	localparam int MoveBits = 4;
	localparam int IdleBits = 5;
	localparam logic [MoveBits-1:0] MoveMax = '1;
	localparam logic [IdleBits-1:0] IdleMax = '1;

	// Register indexes
	localparam logic [CfgIndexBits-1:0] CfgMinTicks = 1'b0;
	localparam logic [CfgIndexBits-1:0] CfgStopThreshold = 1'b1;

	// Register reset values
	localparam logic [MinTicksBits-1:0] MinTicksReset = 4'd1;
	localparam logic [StopBits-1:0] StopReset = 5'd5;

	// Event codes
	localparam logic [1:0] EvNone = 2'd0;
	localparam logic [1:0] EvPress = 2'd1;
	localparam logic [1:0] EvRelease = 2'd2;

	// Key codes
	localparam logic KeyA = 1'b0;
	localparam logic KeyS = 1'b1;

	typedef struct packed {
		logic [1:0] key_event;
		logic key_id;
		logic scratching;
	} tsd_result_t;

endpackage

// ----- rtl/turntable_scratch_detector_unit.sv -----
// Turntable scratch detector top level: input register, configuration
// registers, output register. Depends on tsd_pkg and tsd_core.
// Data path: a sample goes through the input register, then the output
// register; a stall on the output holds it in the input register.
// Throughput: one sample per cycle unless out_stall holds the output register.
// Reset: arst_n clears the pipeline valids and the detector state, and sets
// min_ticks to 1 and stop_threshold to 5.
`timescale 1ns / 1ps

module turntable_scratch_detector_unit
	import tsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [PosInBits-1:0] position,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] key_event,
	output logic key_id,
	output logic scratching,
	input  logic cfg_wr_en,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0] cfg_data
);

	logic valid_s1;
	logic [PosBits-1:0] pos_s1;
	logic valid_s2;
	tsd_result_t result_s2;
	logic [MinTicksBits-1:0] min_ticks_q;
	logic [StopBits-1:0] stop_threshold_q;
	logic advance;
	tsd_result_t result;

	// Stage 1 moves on when the output register is free or being emptied
	assign advance = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ticks_q <= MinTicksReset;
			stop_threshold_q <= StopReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CfgMinTicks: min_ticks_q <= cfg_data[MinTicksBits-1:0];
				CfgStopThreshold: stop_threshold_q <= cfg_data[StopBits-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pos_s1 <= position[PosBits-1:0];
		end
	end

	tsd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.cur            (pos_s1),
		.min_ticks      (min_ticks_q),
		.stop_threshold (stop_threshold_q),
		.result         (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign key_event = result_s2.key_event;
	assign key_id = result_s2.key_id;
	assign scratching = result_s2.scratching;

endmodule

// ----- rtl/tsd_core.sv -----
// Scratch detector state and per-sample update logic.
// Depends on tsd_pkg and turntable_scratch_detector_unit_defines.svh.
`timescale 1ns / 1ps
`include "turntable_scratch_detector_unit_defines.svh"

module tsd_core
	import tsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [PosBits-1:0] cur,
	input  logic [MinTicksBits-1:0] min_ticks,
	input  logic [StopBits-1:0] stop_threshold,
	output tsd_result_t result
);

	localparam logic [PosBits-1:0] Half = {1'b1, {(PosBits-1){1'b0}}};

	logic [PosBits-1:0] last_q;
	logic primed_q;
	logic active_q;
	logic cw_q;
	logic [MoveBits-1:0] move_q;
	logic [IdleBits-1:0] idle_q;

	logic [PosBits-1:0] last_d;
	logic primed_d;
	logic active_d;
	logic cw_d;
	logic [MoveBits-1:0] move_d;
	logic [IdleBits-1:0] idle_d;

	logic [PosBits-1:0] diff;
	logic now_cw;
	logic [MoveBits-1:0] move_inc;
	logic [IdleBits-1:0] idle_inc;

	// Wrapped step and its direction; a half turn goes by the raw compare
	always_comb begin
		diff = cur - last_q;
		if (diff < Half) begin
			now_cw = 1'b1;
		end else if (diff > Half) begin
			now_cw = 1'b0;
		end else begin
			now_cw = cur > last_q;
		end
		move_inc = (move_q == MoveMax) ? move_q : move_q + 1'b1;
		idle_inc = (idle_q == IdleMax) ? idle_q : idle_q + 1'b1;
	end

	// Next state and event for the current sample
	always_comb begin
		last_d = last_q;
		primed_d = primed_q;
		active_d = active_q;
		cw_d = cw_q;
		move_d = move_q;
		idle_d = idle_q;
		result.key_event = EvNone;
		result.key_id = KeyA;
		if (!primed_q) begin
			primed_d = 1'b1;
			last_d = cur;
		end else if (diff != '0) begin
			if (active_q && (cw_q != now_cw)) begin
				// reversal: let go of the held key, start counting again
				result.key_event = EvRelease;
				result.key_id = cw_q ? KeyA : KeyS;
				active_d = 1'b0;
				move_d = '0;
				cw_d = now_cw;
			end else if (!active_q) begin
				move_d = move_inc;
				if (move_inc >= min_ticks) begin
					active_d = 1'b1;
					cw_d = now_cw;
					result.key_event = EvPress;
					result.key_id = now_cw ? KeyA : KeyS;
				end
			end
			idle_d = '0;
			last_d = cur;
		end else begin
			idle_d = idle_inc;
			if ((idle_inc > stop_threshold) && active_q) begin
				active_d = 1'b0;
				move_d = '0;
				result.key_event = EvRelease;
				result.key_id = cw_q ? KeyA : KeyS;
			end
		end
		result.scratching = active_d;
	end

	// Detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			primed_q <= 1'b0;
			active_q <= 1'b0;
			cw_q <= 1'b0;
			move_q <= '0;
			idle_q <= '0;
		end else if (step) begin
			last_q <= last_d;
			primed_q <= primed_d;
			active_q <= active_d;
			cw_q <= cw_d;
			move_q <= move_d;
			idle_q <= idle_d;
		end
	end

	`TSD_ASSERT_SAME(a_press_holds, step && result.key_event == EvPress, result.scratching, "press without held key")
	`TSD_ASSERT_SAME(a_release_frees, step && result.key_event == EvRelease, !result.scratching, "release with key still held")
	`TSD_ASSERT_NEXT(a_state_holds, !step, active_q == $past(active_q) && last_q == $past(last_q), "state changed without a sample")
	`TSD_ASSERT_NEXT(a_idle_sat, step && primed_q && diff == '0 && idle_q == IdleMax, idle_q == IdleMax, "idle count wrapped")

endmodule
